### hdl/lrrfb_pkg.sv
// Shared types and constants for the rotated-framebuffer line rasterizer.
`timescale 1ns / 1ps
`default_nettype none

package lrrfb_pkg;

    localparam int SCREEN_HEIGHT = 240;
    localparam int X_LIMIT       = 512;

    localparam int XW      = 9;
    localparam int YW      = 8;
    localparam int ERR_W   = 12;
    localparam int ADDR_W  = 19;
    localparam int COLOR_W = 24;

    localparam logic OP_START   = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

    typedef struct packed {
        logic               op;
        logic [XW-1:0]      x_start;
        logic [YW-1:0]      y_start;
        logic [XW-1:0]      x_finish;
        logic [YW-1:0]      y_finish;
        logic [COLOR_W-1:0] color;
    } cmd_t;

    typedef struct packed {
        logic [ADDR_W-1:0] byte_address;
        logic [7:0]        low_byte;
        logic [7:0]        mid_byte;
        logic [7:0]        high_byte;
        logic              last_pixel;
    } pix_t;

    // Pixel produced by one step, before address generation.
    typedef struct packed {
        logic               emit;
        logic [XW-1:0]      x;
        logic [YW-1:0]      y;
        logic               last;
        logic [COLOR_W-1:0] color;
    } step_t;

endpackage

`default_nettype wire

### hdl/lrrfb_step.sv
// Bresenham line state and per-request stepping logic.
`timescale 1ns / 1ps
`default_nettype none

module lrrfb_step
    import lrrfb_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  go,
    input  wire cmd_t  cmd,
    output step_t      step
);

    logic                    busy_reg, busy_next;
    logic [XW-1:0]           cur_x_reg, cur_x_next;
    logic [YW-1:0]           cur_y_reg, cur_y_next;
    logic [XW-1:0]           major_end_reg, major_end_next;
    logic signed [ERR_W-1:0] err_reg, err_next;
    logic [XW-1:0]           abs_dx_reg, abs_dx_next;
    logic [YW-1:0]           abs_dy_reg, abs_dy_next;
    logic                    x_major_reg, x_major_next;
    logic                    minor_up_reg, minor_up_next;
    logic [COLOR_W-1:0]      color_reg, color_next;

    logic [XW-1:0]           x1, x2, x_inc, x_dec;
    logic signed [XW:0]      dx;
    logic signed [YW:0]      dy;
    logic [XW-1:0]           adx;
    logic [YW-1:0]           ady;
    logic signed [ERR_W-1:0] twice_dx, twice_dy;
    logic                    last;
    logic                    emit;

    // x is reduced modulo X_LIMIT by one compare-subtract (inputs stay below 2*X_LIMIT)
    always_comb
    begin
        x1 = ({1'b0, cmd.x_start} >= (XW+1)'(X_LIMIT))
           ? XW'({1'b0, cmd.x_start} - (XW+1)'(X_LIMIT)) : cmd.x_start;
        x2 = ({1'b0, cmd.x_finish} >= (XW+1)'(X_LIMIT))
           ? XW'({1'b0, cmd.x_finish} - (XW+1)'(X_LIMIT)) : cmd.x_finish;
        dx  = $signed({1'b0, x2}) - $signed({1'b0, x1});
        dy  = $signed({1'b0, cmd.y_finish}) - $signed({1'b0, cmd.y_start});
        adx = dx[XW] ? XW'(-dx) : XW'(dx);
        ady = dy[YW] ? YW'(-dy) : YW'(dy);
        x_inc = (cur_x_reg == XW'(X_LIMIT - 1)) ? '0 : cur_x_reg + XW'(1);
        x_dec = (cur_x_reg == '0) ? XW'(X_LIMIT - 1) : cur_x_reg - XW'(1);
        twice_dx = $signed({{(ERR_W-XW-1){1'b0}}, abs_dx_reg, 1'b0});
        twice_dy = $signed({{(ERR_W-YW-1){1'b0}}, abs_dy_reg, 1'b0});
    end

    always_comb
    begin
        busy_next      = busy_reg;
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        major_end_next = major_end_reg;
        err_next       = err_reg;
        abs_dx_next    = abs_dx_reg;
        abs_dy_next    = abs_dy_reg;
        x_major_next   = x_major_reg;
        minor_up_next  = minor_up_reg;
        color_next     = color_reg;
        last           = 1'b0;
        emit           = 1'b0;

        if (cmd.op == OP_START)
        begin
            emit          = 1'b1;
            abs_dx_next   = adx;
            abs_dy_next   = ady;
            minor_up_next = (dx[XW] && dy[YW]) || ((dx > 0) && (dy > 0));
            color_next    = cmd.color;
            x_major_next  = {1'b0, ady} <= adx;
            if ({1'b0, ady} <= adx)
            begin
                err_next = $signed({{(ERR_W-YW-1){1'b0}}, ady, 1'b0})
                         - $signed({{(ERR_W-XW){1'b0}}, adx});
                if (!dx[XW])
                begin
                    cur_x_next = x1; cur_y_next = cmd.y_start; major_end_next = x2;
                end
                else
                begin
                    cur_x_next = x2; cur_y_next = cmd.y_finish; major_end_next = x1;
                end
                last = cur_x_next >= major_end_next;
            end
            else
            begin
                err_next = $signed({{(ERR_W-XW-1){1'b0}}, adx, 1'b0})
                         - $signed({{(ERR_W-YW){1'b0}}, ady});
                if (!dy[YW])
                begin
                    cur_x_next = x1; cur_y_next = cmd.y_start;
                    major_end_next = XW'(cmd.y_finish);
                end
                else
                begin
                    cur_x_next = x2; cur_y_next = cmd.y_finish;
                    major_end_next = XW'(cmd.y_start);
                end
                last = XW'(cur_y_next) >= major_end_next;
            end
            busy_next = !last;
        end
        else if (busy_reg)
        begin
            emit = 1'b1;
            if (x_major_reg)
            begin
                cur_x_next = x_inc;
                if (err_reg < 0)
                    err_next = err_reg + twice_dy;
                else
                begin
                    cur_y_next = minor_up_reg ? cur_y_reg + YW'(1) : cur_y_reg - YW'(1);
                    err_next   = err_reg + twice_dy - twice_dx;
                end
                last = cur_x_next >= major_end_reg;
            end
            else
            begin
                cur_y_next = cur_y_reg + YW'(1);
                // y-major tests with <= 0
                if (err_reg <= 0)
                    err_next = err_reg + twice_dx;
                else
                begin
                    cur_x_next = minor_up_reg ? x_inc : x_dec;
                    err_next   = err_reg + twice_dx - twice_dy;
                end
                last = XW'(cur_y_next) >= major_end_reg;
            end
            busy_next = !last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            major_end_reg <= '0;
            err_reg       <= '0;
            abs_dx_reg    <= '0;
            abs_dy_reg    <= '0;
            x_major_reg   <= 1'b0;
            minor_up_reg  <= 1'b0;
            color_reg     <= '0;
        end
        else if (go)
        begin
            busy_reg      <= busy_next;
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
            major_end_reg <= major_end_next;
            err_reg       <= err_next;
            abs_dx_reg    <= abs_dx_next;
            abs_dy_reg    <= abs_dy_next;
            x_major_reg   <= x_major_next;
            minor_up_reg  <= minor_up_next;
            color_reg     <= color_next;
        end
    end

    assign step.emit  = emit;
    assign step.x     = cur_x_next;
    assign step.y     = cur_y_next;
    assign step.last  = last;
    assign step.color = color_next;

endmodule

`default_nettype wire

### hdl/lrrfb_addr.sv
// Rotated framebuffer byte address: ((H - y - 1) + x*H) * 3, modulo 2^ADDR_W.
`timescale 1ns / 1ps
`default_nettype none

module lrrfb_addr
    import lrrfb_pkg::*;
(
    input  wire logic [XW-1:0] x,
    input  wire logic [YW-1:0] y,
    output logic [ADDR_W-1:0]  byte_address
);

    logic [ADDR_W-1:0] col_base;
    logic [ADDR_W-1:0] pix_index;

    always_comb
    begin
        col_base     = ADDR_W'(x) * ADDR_W'(SCREEN_HEIGHT);
        pix_index    = ADDR_W'(SCREEN_HEIGHT - 1) - ADDR_W'(y) + col_base;
        byte_address = pix_index + {pix_index[ADDR_W-2:0], 1'b0};
    end

endmodule

`default_nettype wire

### hdl/line_rasterizer_rotated_fb_unit.sv
// Top level of the Bresenham line rasterizer for a 90-degree rotated framebuffer.
`timescale 1ns / 1ps
`default_nettype none

// A start request (op = 0) loads two endpoints and a color and yields the first
// pixel; each advance request (op = 1) yields the next pixel of the line, and the
// pixel that reaches the far endpoint carries last_pixel. An advance while no line
// is active is consumed without a result. One request is taken every clock unless
// the result register holds a pixel that pix_ready stalls. A request waits in the
// command register while the line step and address generation run on it, and its
// pixel is then loaded into the result register, which drives pix_valid. The result
// register frees the command side whenever its pixel is being taken in the same cycle.
module line_rasterizer_rotated_fb_unit
    import lrrfb_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cmd_valid,
    output logic      cmd_ready,
    input  wire cmd_t cmd,
    output logic      pix_valid,
    input  wire logic pix_ready,
    output pix_t      pix
);

    cmd_t              cmd_reg;
    logic              cmd_vld_reg;
    pix_t              pix_reg, pix_next;
    logic              pix_vld_reg;
    logic              adv;
    step_t             step;
    logic [ADDR_W-1:0] addr;

    assign adv       = cmd_vld_reg && (!pix_vld_reg || pix_ready);
    assign cmd_ready = !cmd_vld_reg || adv;

    lrrfb_step u_step (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (adv),
        .cmd   (cmd_reg),
        .step  (step)
    );

    lrrfb_addr u_addr (
        .x            (step.x),
        .y            (step.y),
        .byte_address (addr)
    );

    always_comb
    begin
        pix_next.byte_address = addr;
        pix_next.low_byte     = step.color[7:0];
        pix_next.mid_byte     = step.color[15:8];
        pix_next.high_byte    = step.color[23:16];
        pix_next.last_pixel   = step.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_vld_reg <= 1'b0;
            pix_vld_reg <= 1'b0;
        end
        else
        begin
            if (cmd_valid && cmd_ready)
                cmd_vld_reg <= 1'b1;
            else if (adv)
                cmd_vld_reg <= 1'b0;

            if (adv)
                pix_vld_reg <= step.emit;
            else if (pix_ready)
                pix_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid && cmd_ready)
            cmd_reg <= cmd;
        if (adv && step.emit)
            pix_reg <= pix_next;
    end

    assign pix_valid = pix_vld_reg;
    assign pix       = pix_reg;

endmodule

`default_nettype wire

### tb/rasterizer_pixel_checker.sv
// Pixel checker for the rotated-framebuffer line rasterizer: predicts and compares pixels.
`timescale 1ns / 1ps

module rasterizer_pixel_checker
    import lrrfb_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cmd_valid,
    input  wire logic cmd_ready,
    input  wire cmd_t cmd,
    input  wire logic pix_valid,
    input  wire logic pix_ready,
    input  wire pix_t pix,
    output int        mismatches,
    output int        pixels_left,
    output int        pixels_checked
);

    // Shadow of the line engine; 2-state so it starts at its reset value.
    bit                 line_busy;
    bit [XW-1:0]        cur_x;
    bit [YW-1:0]        cur_y;
    bit [XW-1:0]        major_end;
    int                 err;
    bit [XW-1:0]        abs_dx;
    bit [YW-1:0]        abs_dy;
    bit                 x_major;
    bit                 minor_up;
    bit [COLOR_W-1:0]   line_color;

    pix_t expected_pixels[$];

    // Applies one request to the shadow state; returns 1 when it yields a pixel.
    function automatic bit rasterize(input cmd_t req, output pix_t px);
        int          x1, y1, x2, y2, dx, dy;
        bit          at_end;
        int unsigned hgt, addr;
        px = '0;
        if (req.op == OP_START) begin
            x1 = int'(req.x_start) % X_LIMIT;
            y1 = int'(req.y_start);
            x2 = int'(req.x_finish) % X_LIMIT;
            y2 = int'(req.y_finish);
            dx = x2 - x1;
            dy = y2 - y1;
            abs_dx = XW'((dx < 0) ? -dx : dx);
            abs_dy = YW'((dy < 0) ? -dy : dy);
            minor_up = (dx < 0 && dy < 0) || (dx > 0 && dy > 0);
            line_color = req.color;
            x_major = (int'(abs_dy) <= int'(abs_dx));
            if (x_major) begin
                err = 2 * int'(abs_dy) - int'(abs_dx);
                if (dx >= 0) begin
                    cur_x = XW'(x1); cur_y = YW'(y1); major_end = XW'(x2);
                end
                else begin
                    cur_x = XW'(x2); cur_y = YW'(y2); major_end = XW'(x1);
                end
                at_end = (cur_x >= major_end);
            end
            else begin
                err = 2 * int'(abs_dx) - int'(abs_dy);
                if (dy >= 0) begin
                    cur_x = XW'(x1); cur_y = YW'(y1); major_end = XW'(y2);
                end
                else begin
                    cur_x = XW'(x2); cur_y = YW'(y2); major_end = XW'(y1);
                end
                at_end = ({1'b0, cur_y} >= major_end);
            end
        end
        else begin
            if (!line_busy)
                return 1'b0;
            if (x_major) begin
                cur_x = XW'((int'(cur_x) + 1) % X_LIMIT);
                // x-major: minor step skipped only on a strictly negative error
                if (err < 0) begin
                    err += 2 * int'(abs_dy);
                end
                else begin
                    cur_y = minor_up ? cur_y + 1'b1 : cur_y - 1'b1;
                    err += 2 * (int'(abs_dy) - int'(abs_dx));
                end
                at_end = (cur_x >= major_end);
            end
            else begin
                cur_y = cur_y + 1'b1;
                // y-major: zero error also skips the minor step
                if (err <= 0) begin
                    err += 2 * int'(abs_dx);
                end
                else begin
                    cur_x = minor_up ? XW'((int'(cur_x) + 1) % X_LIMIT)
                                     : XW'((int'(cur_x) + X_LIMIT - 1) % X_LIMIT);
                    err += 2 * (int'(abs_dx) - int'(abs_dy));
                end
                at_end = ({1'b0, cur_y} >= major_end);
            end
        end
        line_busy = !at_end;
        // rotated layout; rows past the screen height wrap and are cut to ADDR_W bits like the hardware
        hgt  = SCREEN_HEIGHT;
        addr = ((hgt - cur_y - 1) + cur_x * hgt) * 3;
        px.byte_address = addr[ADDR_W-1:0];
        px.low_byte     = line_color[7:0];
        px.mid_byte     = line_color[15:8];
        px.high_byte    = line_color[23:16];
        px.last_pixel   = at_end;
        return 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        pix_t want, made;
        bit   bad;
        if (!rst_n)
        begin
            line_busy  = 1'b0;
            cur_x      = '0;
            cur_y      = '0;
            major_end  = '0;
            err        = 0;
            abs_dx     = '0;
            abs_dy     = '0;
            x_major    = 1'b0;
            minor_up   = 1'b0;
            line_color = '0;
            expected_pixels.delete();
            pixels_left = 0;
        end
        else
        begin
            // a request passes the command and result registers before it reaches the output, so check first
            if (pix_valid && pix_ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $error("pixel with no request pending: byte_address %0d",
                           pix.byte_address);
                    mismatches++;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    bad  = 1'b0;
                    if (pix.byte_address !== want.byte_address)
                    begin
                        $error("byte_address: expected %0d, got %0d",
                               want.byte_address, pix.byte_address);
                        bad = 1'b1;
                    end
                    if (pix.low_byte !== want.low_byte)
                    begin
                        $error("low_byte: expected %0h, got %0h", want.low_byte, pix.low_byte);
                        bad = 1'b1;
                    end
                    if (pix.mid_byte !== want.mid_byte)
                    begin
                        $error("mid_byte: expected %0h, got %0h", want.mid_byte, pix.mid_byte);
                        bad = 1'b1;
                    end
                    if (pix.high_byte !== want.high_byte)
                    begin
                        $error("high_byte: expected %0h, got %0h",
                               want.high_byte, pix.high_byte);
                        bad = 1'b1;
                    end
                    if (pix.last_pixel !== want.last_pixel)
                    begin
                        $error("last_pixel: expected %0b, got %0b",
                               want.last_pixel, pix.last_pixel);
                        bad = 1'b1;
                    end
                    if (bad)
                        mismatches++;
                    pixels_checked++;
                end
            end
            if (cmd_valid && cmd_ready)
            begin
                if (rasterize(cmd, made))
                    expected_pixels.push_back(made);
            end
            pixels_left = expected_pixels.size();
        end
    end

endmodule

### tb/line_rasterizer_rotated_fb_unit_tb.sv
// Testbench top for the rotated-framebuffer line rasterizer: stimulus and verdict.
`timescale 1ns / 1ps

module line_rasterizer_rotated_fb_unit_tb
    import lrrfb_pkg::*;
();

    localparam int DRAIN_CYCLES = 8;
    localparam int X_MAX        = X_LIMIT - 1;

    logic clk;
    logic rst_n;
    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;
    logic pix_valid;
    logic pix_ready;
    pix_t pix;

    int mismatches;
    int pixels_left;
    int pixels_checked;

    int requests_sent;
    int lines_started;
    int line_items;
    bit gaps_on;
    bit stalls_on;

    line_rasterizer_rotated_fb_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix       (pix)
    );

    rasterizer_pixel_checker pixel_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_valid      (cmd_valid),
        .cmd_ready      (cmd_ready),
        .cmd            (cmd),
        .pix_valid      (pix_valid),
        .pix_ready      (pix_ready),
        .pix            (pix),
        .mismatches     (mismatches),
        .pixels_left    (pixels_left),
        .pixels_checked (pixels_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // mostly short idle stretches, now and then a long one
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    initial
    begin : pix_ready_drive
        int stall_left;
        stall_left = 0;
        pix_ready  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                pix_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                pix_ready <= 1'b1;
                if (stalls_on && $urandom_range(0, 99) < 25)
                    stall_left = idle_length();
            end
        end
    end

    function automatic cmd_t start_request(int x1, int y1, int x2, int y2,
                                           logic [COLOR_W-1:0] color);
        cmd_t c;
        c.op       = OP_START;
        c.x_start  = XW'(x1);
        c.y_start  = YW'(y1);
        c.x_finish = XW'(x2);
        c.y_finish = YW'(y2);
        c.color    = color;
        return c;
    endfunction

    // advance carries random don't-care payload
    function automatic cmd_t advance_request();
        cmd_t c;
        {c.x_start, c.y_start, c.x_finish, c.y_finish} = 34'({$urandom(), $urandom()});
        c.color = COLOR_W'($urandom());
        c.op    = OP_ADVANCE;
        return c;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_request(input cmd_t item);
        int gap;
        gap = (gaps_on && $urandom_range(0, 99) < 30) ? idle_length() : 0;
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= item;
        do
            @(posedge clk);
        while (!cmd_ready);
        @(negedge clk);
        requests_sent++;
    endtask

    task automatic draw_line(input int x1, input int y1, input int x2, input int y2,
                             input logic [COLOR_W-1:0] color, input int advances);
        int steps, dxa, dya;
        dxa   = (x2 > x1) ? x2 - x1 : x1 - x2;
        dya   = (y2 > y1) ? y2 - y1 : y1 - y2;
        steps = (dxa > dya) ? dxa : dya;
        send_request(start_request(x1, y1, x2, y2, color));
        lines_started++;
        for (int i = 0; i < advances; i++)
            send_request(advance_request());
        // advances past the end are ignored by the block
        line_items += 1 + ((advances < steps) ? advances : steps);
    endtask

    // Pause the sender until every pixel is in, then wait out the DRAIN_CYCLES margin.
    task automatic settle();
        cmd_valid <= 1'b0;
        @(negedge clk);
        while (pixels_left != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic random_line();
        int x1, y1, x2, y2, ymax, r, steps, dxa, dya, adv;
        ymax = ($urandom_range(0, 9) == 0) ? 255 : SCREEN_HEIGHT - 1;
        r    = $urandom_range(0, 199);
        if (r < 2)
        begin
            // full-width line, rarely: 512 pixels
            x1 = ($urandom_range(0, 1) != 0) ? 0 : X_MAX;
            x2 = X_MAX - x1;
            y1 = $urandom_range(0, ymax);
            y2 = $urandom_range(0, ymax);
        end
        else
        begin
            x1 = $urandom_range(0, X_MAX);
            y1 = $urandom_range(0, ymax);
            if (r < 24)
            begin
                x2 = x1 + $urandom_range(0, 160) - 80;
                y2 = y1 + $urandom_range(0, 160) - 80;
            end
            else
            begin
                x2 = x1 + $urandom_range(0, 24) - 12;
                y2 = y1 + $urandom_range(0, 24) - 12;
            end
            if (x2 < 0) x2 = 0;
            if (x2 > X_MAX) x2 = X_MAX;
            if (y2 < 0) y2 = 0;
            if (y2 > ymax) y2 = ymax;
        end
        dxa   = (x2 > x1) ? x2 - x1 : x1 - x2;
        dya   = (y2 > y1) ? y2 - y1 : y1 - y2;
        steps = (dxa > dya) ? dxa : dya;
        r     = $urandom_range(0, 99);
        if (r < 80)
            adv = steps;
        else if (r < 90)
            adv = $urandom_range(0, steps);   // next start cuts the line short
        else
            adv = steps + $urandom_range(1, 3);
        draw_line(x1, y1, x2, y2, COLOR_W'($urandom()), adv);
        if ($urandom_range(0, 99) < 5)
            send_request(advance_request());
    endtask

    task automatic random_phase(input int item_goal, input bit with_gaps,
                                input bit with_stalls);
        gaps_on   = with_gaps;
        stalls_on = with_stalls;
        while (line_items < item_goal)
            random_line();
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cmd_valid     = 1'b0;
        cmd           = '0;
        gaps_on       = 1'b1;
        stalls_on     = 1'b1;
        requests_sent = 0;
        lines_started = 0;
        line_items    = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: idle advance, single point, both majors in both directions,
        // rows past the screen height, restart of a busy line, exact diagonal
        send_request(advance_request());
        draw_line(0, 0, 0, 0, 24'hFFFFFF, 0);
        draw_line(0, SCREEN_HEIGHT - 1, 3, SCREEN_HEIGHT - 1, 24'h000000, 3);
        draw_line(X_MAX, 0, X_MAX - 3, 2, 24'h123456, 3);
        draw_line(10, 20, 12, 15, 24'hA5C3F0, 5);
        draw_line(100, 250, 101, 252, 24'h00FF00, 2);
        draw_line(0, 0, 5, 0, 24'h0F0F0F, 1);
        draw_line(X_MAX, 255, X_MAX, 255, 24'hF0F0F0, 0);
        draw_line(0, 0, 2, 2, 24'h800001, 2);
        settle();

        random_phase(600, 1'b1, 1'b1);
        settle();
        random_phase(900, 1'b0, 1'b0);
        settle();
        random_phase(1150, 1'b1, 1'b0);
        random_phase(1400, 1'b0, 1'b1);
        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d requests with %0d line starts; %0d pixels compared.",
                 requests_sent, lines_started, pixels_checked);
        $display("Mix: single points, cut-short lines, idle advances, rows past screen height.");
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### filelist.f
hdl/lrrfb_pkg.sv
hdl/lrrfb_step.sv
hdl/lrrfb_addr.sv
hdl/line_rasterizer_rotated_fb_unit.sv
tb/rasterizer_pixel_checker.sv
tb/line_rasterizer_rotated_fb_unit_tb.sv
